FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define LFS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define LFS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: sv/lfs_pkg.sv
package lfs_pkg;

    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_ARM  = 2'd1;
    localparam logic [1:0] FUNC_BOOT = 2'd2;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_BOOT   = 2'd1;
    localparam logic [1:0] MODE_ERROR  = 2'd2;
    localparam logic [1:0] MODE_OFF    = 2'd3;

    localparam logic [2:0] COL_INTERNAL = 3'd0;
    localparam logic [2:0] COL_RED      = 3'd1;
    localparam logic [2:0] COL_GREEN    = 3'd2;
    localparam logic [2:0] COL_BLUE     = 3'd3;
    localparam logic [2:0] COL_YELLOW   = 3'd4;

    localparam logic [2:0] CFG_MODE      = 3'd0;
    localparam logic [2:0] CFG_PRESENT   = 3'd1;
    localparam logic [2:0] CFG_INT_INV   = 3'd2;
    localparam logic [2:0] CFG_RGB_INV   = 3'd3;
    localparam logic [2:0] CFG_METER_PIN = 3'd4;

    localparam int CFG_DATA_W = 4;

    localparam logic [8:0] FAST_ON_MS  = 9'd80;
    localparam logic [8:0] FAST_OFF_MS = 9'd160;
    localparam logic [8:0] SLOW_ON_MS  = 9'd250;
    localparam logic [8:0] SLOW_OFF_MS = 9'd400;
    localparam logic [8:0] ELAPSED_MAX = 9'd511;

    typedef struct packed {
        logic [1:0] behaviour_mode;
        logic [3:0] present_mask;
        logic       internal_invert;
        logic       rgb_invert;
        logic       meter_pin_present;
    } t_cfg;

    typedef struct packed {
        logic [1:0] func;
        logic [2:0] color;
        logic [7:0] count;
        logic       fast;
        logic       suppress;
        logic       boot_ok;
    } t_item;

    typedef struct packed {
        logic internal_level;
        logic red_level;
        logic green_level;
        logic blue_level;
        logic meter_enable_level;
        logic busy_res;
        logic accepted;
    } t_result;

endpackage

FILE: sv/lfs_core.sv
module lfs_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lfs_pkg::t_cfg  i_cfg,
    input  logic           i_en,
    input  lfs_pkg::t_item i_item,
    output lfs_pkg::t_result o_result
);

    logic [7:0] r_flashes_left, n_flashes_left;
    logic       r_phase_on, n_phase_on;
    logic       r_first_pending, n_first_pending;
    logic [8:0] r_elapsed_ms, n_elapsed_ms;
    logic [2:0] r_burst_color, n_burst_color;
    logic       r_burst_fast, n_burst_fast;
    logic       r_burst_suppress, n_burst_suppress;
    logic       r_boot_done, n_boot_done;
    logic [3:0] r_led_lit, n_led_lit;
    logic       r_meter_level, n_meter_level;

    logic [8:0] w_elapsed_inc;
    logic [8:0] w_on_ms;
    logic [8:0] w_off_ms;
    logic [3:0] w_burst_leds;
    logic [3:0] w_arm_leds;
    logic [3:0] w_shown;
    logic       w_acc;

    function automatic logic [3:0] color_leds(input logic [2:0] c, input logic [3:0] present);
        logic [3:0] m;
        begin
            case (c)
                lfs_pkg::COL_INTERNAL: m = 4'b0001;
                lfs_pkg::COL_RED:      m = 4'b0010;
                lfs_pkg::COL_GREEN:    m = 4'b0100;
                lfs_pkg::COL_BLUE:     m = 4'b1000;
                lfs_pkg::COL_YELLOW:   m = 4'b0110;
                default:               m = 4'b0000;
            endcase
            color_leds = ((present & m) == m) ? m : 4'b0000;
        end
    endfunction

    function automatic logic mode_allows(input logic [2:0] c, input logic [1:0] mode,
                                         input logic boot_done);
        begin
            mode_allows = 1'b1;
            if (mode == lfs_pkg::MODE_OFF) begin
                mode_allows = 1'b0;
            end else if (mode == lfs_pkg::MODE_ERROR && c != lfs_pkg::COL_RED) begin
                mode_allows = 1'b0;
            end else if (mode == lfs_pkg::MODE_BOOT && c != lfs_pkg::COL_RED && boot_done) begin
                mode_allows = 1'b0;
            end
        end
    endfunction

    function automatic logic meter_for_mode(input logic [1:0] mode, input logic boot_done);
        begin
            case (mode)
                lfs_pkg::MODE_ERROR, lfs_pkg::MODE_OFF: meter_for_mode = 1'b0;
                lfs_pkg::MODE_BOOT:                     meter_for_mode = !boot_done;
                default:                                meter_for_mode = 1'b1;
            endcase
        end
    endfunction

    assign w_elapsed_inc = (r_elapsed_ms < lfs_pkg::ELAPSED_MAX) ? r_elapsed_ms + 9'd1
                                                                : r_elapsed_ms;
    assign w_on_ms      = r_burst_fast ? lfs_pkg::FAST_ON_MS : lfs_pkg::SLOW_ON_MS;
    assign w_off_ms     = r_burst_fast ? lfs_pkg::FAST_OFF_MS : lfs_pkg::SLOW_OFF_MS;
    assign w_burst_leds = color_leds(r_burst_color, i_cfg.present_mask);
    assign w_arm_leds   = color_leds(i_item.color, i_cfg.present_mask);

    always_comb begin
        n_flashes_left   = r_flashes_left;
        n_phase_on       = r_phase_on;
        n_first_pending  = r_first_pending;
        n_elapsed_ms     = r_elapsed_ms;
        n_burst_color    = r_burst_color;
        n_burst_fast     = r_burst_fast;
        n_burst_suppress = r_burst_suppress;
        n_boot_done      = r_boot_done;
        n_led_lit        = r_led_lit;
        n_meter_level    = r_meter_level;
        w_acc            = 1'b0;
        case (i_item.func)
            lfs_pkg::FUNC_TICK: begin
                if (r_flashes_left != 8'd0) begin
                    n_elapsed_ms = w_elapsed_inc;
                    if (r_phase_on) begin
                        if (w_elapsed_inc >= w_on_ms) begin
                            n_led_lit      = r_led_lit & ~w_burst_leds;
                            n_phase_on     = 1'b0;
                            n_elapsed_ms   = 9'd0;
                            n_flashes_left = r_flashes_left - 8'd1;
                            if (r_flashes_left == 8'd1 && r_burst_suppress) begin
                                if (i_cfg.meter_pin_present) begin
                                    n_meter_level = meter_for_mode(i_cfg.behaviour_mode,
                                                                   r_boot_done);
                                end
                                n_burst_suppress = 1'b0;
                            end
                        end
                    end else if (r_first_pending || w_elapsed_inc >= w_off_ms) begin
                        if (mode_allows(r_burst_color, i_cfg.behaviour_mode, r_boot_done)) begin
                            n_led_lit = r_led_lit | w_burst_leds;
                        end
                        n_phase_on      = 1'b1;
                        n_first_pending = 1'b0;
                        n_elapsed_ms    = 9'd0;
                    end
                end
            end
            lfs_pkg::FUNC_ARM: begin
                if (i_item.count != 8'd0 && w_arm_leds != 4'd0 &&
                    mode_allows(i_item.color, i_cfg.behaviour_mode, r_boot_done)) begin
                    w_acc = 1'b1;
                    if (r_flashes_left == 8'd0) begin
                        n_burst_color    = i_item.color;
                        n_flashes_left   = i_item.count;
                        n_burst_fast     = i_item.fast;
                        n_phase_on       = 1'b0;
                        n_first_pending  = 1'b1;
                        n_elapsed_ms     = 9'd0;
                        n_burst_suppress = i_item.suppress;
                        if (i_item.suppress && i_cfg.meter_pin_present) begin
                            n_meter_level = 1'b0;
                        end
                    end
                end
            end
            lfs_pkg::FUNC_BOOT: begin
                if (!(r_boot_done && i_item.boot_ok)) begin
                    n_boot_done = i_item.boot_ok;
                    if (i_cfg.meter_pin_present) begin
                        n_meter_level = meter_for_mode(i_cfg.behaviour_mode, i_item.boot_ok);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign w_shown = n_led_lit & i_cfg.present_mask;

    always_comb begin
        o_result.internal_level     = w_shown[0] ^ i_cfg.internal_invert;
        o_result.red_level          = w_shown[1] ^ i_cfg.rgb_invert;
        o_result.green_level        = w_shown[2] ^ i_cfg.rgb_invert;
        o_result.blue_level         = w_shown[3] ^ i_cfg.rgb_invert;
        o_result.meter_enable_level = n_meter_level;
        o_result.busy_res           = (n_flashes_left != 8'd0);
        o_result.accepted           = w_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flashes_left   <= 8'd0;
            r_phase_on       <= 1'b0;
            r_first_pending  <= 1'b0;
            r_elapsed_ms     <= 9'd0;
            r_burst_color    <= 3'd0;
            r_burst_fast     <= 1'b0;
            r_burst_suppress <= 1'b0;
            r_boot_done      <= 1'b0;
            r_led_lit        <= 4'd0;
            r_meter_level    <= 1'b1;
        end else if (i_en) begin
            r_flashes_left   <= n_flashes_left;
            r_phase_on       <= n_phase_on;
            r_first_pending  <= n_first_pending;
            r_elapsed_ms     <= n_elapsed_ms;
            r_burst_color    <= n_burst_color;
            r_burst_fast     <= n_burst_fast;
            r_burst_suppress <= n_burst_suppress;
            r_boot_done      <= n_boot_done;
            r_led_lit        <= n_led_lit;
            r_meter_level    <= n_meter_level;
        end
    end

endmodule

FILE: sv/led_flash_sequencer_top.sv
// led flash sequencer: one result item for every input item
// the result is registered in r_out, or in r_skid while r_out waits downstream
// throughput: one item per cycle unless stalled, set by a single state update in lfs_core
// a two-entry output stage keeps accepting while one result waits downstream
// reset: synchronous active low, clears burst state, leds off, meter pin high, config zero
module led_flash_sequencer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [lfs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_func,
    input  logic [2:0] i_color,
    input  logic [7:0] i_count,
    input  logic       i_fast,
    input  logic       i_suppress,
    input  logic       i_boot_ok,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_internal_level,
    output logic       o_red_level,
    output logic       o_green_level,
    output logic       o_blue_level,
    output logic       o_meter_enable_level,
    output logic       o_busy_res,
    output logic       o_accepted
);

    lfs_pkg::t_cfg    r_cfg;
    lfs_pkg::t_item   w_item;
    lfs_pkg::t_result w_result;
    lfs_pkg::t_result r_out;
    lfs_pkg::t_result r_skid;
    logic             r_out_valid;
    logic             r_skid_valid;
    logic             w_in_acc;
    logic             w_take;

    assign w_item.func     = i_func;
    assign w_item.color    = i_color;
    assign w_item.count    = i_count;
    assign w_item.fast     = i_fast;
    assign w_item.suppress = i_suppress;
    assign w_item.boot_ok  = i_boot_ok;

    assign w_in_acc = i_valid && !r_skid_valid;
    assign w_take   = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lfs_pkg::CFG_MODE:      r_cfg.behaviour_mode    <= i_cfg_data[1:0];
                lfs_pkg::CFG_PRESENT:   r_cfg.present_mask      <= i_cfg_data[3:0];
                lfs_pkg::CFG_INT_INV:   r_cfg.internal_invert   <= i_cfg_data[0];
                lfs_pkg::CFG_RGB_INV:   r_cfg.rgb_invert        <= i_cfg_data[0];
                lfs_pkg::CFG_METER_PIN: r_cfg.meter_pin_present <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    lfs_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_en     (w_in_acc),
        .i_item   (w_item),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_in_acc) begin
            if (!r_out_valid || w_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (w_in_acc) begin
            if (!r_out_valid || w_take) begin
                r_out <= w_result;
            end else begin
                r_skid <= w_result;
            end
        end
    end

    assign o_stall              = r_skid_valid;
    assign o_valid              = r_out_valid;
    assign o_internal_level     = r_out.internal_level;
    assign o_red_level          = r_out.red_level;
    assign o_green_level        = r_out.green_level;
    assign o_blue_level         = r_out.blue_level;
    assign o_meter_enable_level = r_out.meter_enable_level;
    assign o_busy_res           = r_out.busy_res;
    assign o_accepted           = r_out.accepted;

endmodule

FILE: sv/lfs_checker.sv
`include "assert_macros.svh"

module lfs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_internal_level,
    input logic       o_red_level,
    input logic       o_green_level,
    input logic       o_blue_level,
    input logic       o_meter_enable_level,
    input logic       o_busy_res,
    input logic       o_accepted
);

    logic [6:0] w_result;

    assign w_result = {o_internal_level, o_red_level, o_green_level, o_blue_level,
                       o_meter_enable_level, o_busy_res, o_accepted};

    `LFS_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_valid, "output valid right after reset")
    `LFS_ASSERT(a_stall_needs_valid, o_stall |-> o_valid, "input stalled with empty output")
    `LFS_ASSERT(a_accept_busy, o_valid && o_accepted |-> o_busy_res, "accepted arm without burst")
    `LFS_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid, "stalled result dropped")
    `LFS_ASSERT(a_out_stable, o_valid && i_stall |=> $stable(w_result), "stalled result changed")

endmodule

bind led_flash_sequencer_top lfs_checker u_lfs_checker (.*);

FILE: verif/tb_led_flash_sequencer_top.sv
module tb_led_flash_sequencer_top;

    localparam logic [1:0] FUNC_NOP = 2'd3;
    localparam int LONG_HOLD = 60;
    localparam int PHASE_ITEMS = 80;
    localparam int SPAN_CAP = 120;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_index = lfs_pkg::CFG_MODE;
    logic [lfs_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    lfs_pkg::t_item drv_item = '0;

    logic o_stall;
    logic o_valid;
    logic o_internal_level;
    logic o_red_level;
    logic o_green_level;
    logic o_blue_level;
    logic o_meter_enable_level;
    logic o_busy_res;
    logic o_accepted;

    led_flash_sequencer_top dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_func(drv_item.func),
        .i_color(drv_item.color),
        .i_count(drv_item.count),
        .i_fast(drv_item.fast),
        .i_suppress(drv_item.suppress),
        .i_boot_ok(drv_item.boot_ok),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_internal_level(o_internal_level),
        .o_red_level(o_red_level),
        .o_green_level(o_green_level),
        .o_blue_level(o_blue_level),
        .o_meter_enable_level(o_meter_enable_level),
        .o_busy_res(o_busy_res),
        .o_accepted(o_accepted)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // sequencer state as seen by the checker
    lfs_pkg::t_cfg cfg_now = '0;
    logic [7:0] burst_left = '0;
    logic pulse_on = 1'b0;
    logic await_first = 1'b0;
    logic [8:0] ms_since = '0;
    logic [2:0] burst_col = '0;
    logic burst_quick = 1'b0;
    logic burst_quiet = 1'b0;
    logic boot_seen = 1'b0;
    logic [3:0] lit_mask = '0;
    logic meter_pin = 1'b1;

    lfs_pkg::t_item pending_items[$];
    lfs_pkg::t_result expected_levels[$];
    lfs_pkg::t_result want;

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int gap_left = 0;
    int stall_left = 0;
    int holds_asked = 0;
    int holds_done = 0;
    int errors = 0;
    int items_queued = 0;
    int items_sent = 0;
    int results_seen = 0;
    int bursts_armed = 0;
    int pulses_lit = 0;
    int pulses_dark = 0;

    function automatic logic [3:0] leds_for(logic [2:0] c);
        logic [3:0] m;
        if (c <= lfs_pkg::COL_BLUE) m = 4'b0001 << c;
        else if (c == lfs_pkg::COL_YELLOW) m = 4'b0110;
        else return 4'b0000;
        return ((cfg_now.present_mask & m) == m) ? m : 4'b0000;
    endfunction

    function automatic logic colour_allowed(logic [2:0] c);
        if (cfg_now.behaviour_mode == lfs_pkg::MODE_OFF) return 1'b0;
        if (cfg_now.behaviour_mode == lfs_pkg::MODE_ERROR && c != lfs_pkg::COL_RED) return 1'b0;
        if (cfg_now.behaviour_mode == lfs_pkg::MODE_BOOT && c != lfs_pkg::COL_RED && boot_seen)
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic void refresh_meter();
        if (!cfg_now.meter_pin_present) return;
        case (cfg_now.behaviour_mode)
            lfs_pkg::MODE_ERROR, lfs_pkg::MODE_OFF: meter_pin = 1'b0;
            lfs_pkg::MODE_BOOT: meter_pin = !boot_seen;
            default: meter_pin = 1'b1;
        endcase
    endfunction

    function automatic void advance_ms();
        logic [8:0] on_ms;
        logic [8:0] off_ms;
        if (burst_left == 8'd0) return;
        if (ms_since < lfs_pkg::ELAPSED_MAX) ms_since = ms_since + 9'd1;
        on_ms = burst_quick ? lfs_pkg::FAST_ON_MS : lfs_pkg::SLOW_ON_MS;
        off_ms = burst_quick ? lfs_pkg::FAST_OFF_MS : lfs_pkg::SLOW_OFF_MS;
        if (pulse_on) begin
            if (ms_since >= on_ms) begin
                lit_mask = lit_mask & ~leds_for(burst_col);
                pulse_on = 1'b0;
                ms_since = '0;
                burst_left = burst_left - 8'd1;
                if (burst_left == 8'd0 && burst_quiet) begin
                    refresh_meter();
                    burst_quiet = 1'b0;
                end
            end
        end else if (await_first || ms_since >= off_ms) begin
            if (colour_allowed(burst_col)) begin
                lit_mask = lit_mask | leds_for(burst_col);
                pulses_lit++;
            end else begin
                pulses_dark++;
            end
            pulse_on = 1'b1;
            await_first = 1'b0;
            ms_since = '0;
        end
    endfunction

    function automatic logic try_arm(lfs_pkg::t_item it);
        if (it.count == 8'd0 || !colour_allowed(it.color) || leds_for(it.color) == 4'd0)
            return 1'b0;
        if (burst_left != 8'd0) return 1'b1;
        burst_col = it.color;
        burst_left = it.count;
        burst_quick = it.fast;
        pulse_on = 1'b0;
        await_first = 1'b1;
        ms_since = '0;
        burst_quiet = it.suppress;
        if (it.suppress && cfg_now.meter_pin_present) meter_pin = 1'b0;
        bursts_armed++;
        return 1'b1;
    endfunction

    function automatic lfs_pkg::t_result step_sequencer(lfs_pkg::t_item it);
        lfs_pkg::t_result r;
        logic [3:0] shown;
        r = '0;
        case (it.func)
            lfs_pkg::FUNC_TICK: advance_ms();
            lfs_pkg::FUNC_ARM: r.accepted = try_arm(it);
            lfs_pkg::FUNC_BOOT: begin
                if (!(boot_seen && it.boot_ok)) begin
                    boot_seen = it.boot_ok;
                    refresh_meter();
                end
            end
            default: ;
        endcase
        shown = lit_mask & cfg_now.present_mask;
        r.internal_level = shown[0] ^ cfg_now.internal_invert;
        r.red_level = shown[1] ^ cfg_now.rgb_invert;
        r.green_level = shown[2] ^ cfg_now.rgb_invert;
        r.blue_level = shown[3] ^ cfg_now.rgb_invert;
        r.meter_enable_level = meter_pin;
        r.busy_res = (burst_left != 8'd0);
        return r;
    endfunction

    function automatic int pick_gap(int pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_levels.push_back(step_sequencer(drv_item));
                items_sent++;
            end
            if (!(i_valid && o_stall)) begin
                if (gap_left > 0) begin
                    i_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (pending_items.size() != 0) begin
                    drv_item <= pending_items.pop_front();
                    i_valid <= 1'b1;
                    gap_left <= pick_gap(tx_idle_pct);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left <= 0;
        end else if (holds_done != holds_asked) begin
            i_stall <= 1'b1;
            stall_left <= LONG_HOLD - 1;
            holds_done <= holds_done + 1;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < rx_stall_pct) begin
            i_stall <= 1'b1;
            stall_left <= pick_gap(100) - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic check_bit(string name, logic exp_v, logic act_v);
        if (exp_v !== act_v) begin
            $error("%s expected %0d got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_levels.size() == 0) begin
                $error("result with no item outstanding");
                errors++;
            end else begin
                want = expected_levels.pop_front();
                check_bit("internal_level", want.internal_level, o_internal_level);
                check_bit("red_level", want.red_level, o_red_level);
                check_bit("green_level", want.green_level, o_green_level);
                check_bit("blue_level", want.blue_level, o_blue_level);
                check_bit("meter_enable_level", want.meter_enable_level, o_meter_enable_level);
                check_bit("busy_res", want.busy_res, o_busy_res);
                check_bit("accepted", want.accepted, o_accepted);
            end
        end
    end

    function automatic lfs_pkg::t_item make_item(logic [1:0] f, logic [2:0] c, logic [7:0] n,
                                                 logic q, logic s, logic b);
        lfs_pkg::t_item it;
        it.func = f;
        it.color = c;
        it.count = n;
        it.fast = q;
        it.suppress = s;
        it.boot_ok = b;
        return it;
    endfunction

    function automatic lfs_pkg::t_item rand_item();
        return make_item(2'($urandom_range(0, 3)), 3'($urandom), 8'($urandom),
                         1'($urandom), 1'($urandom), 1'($urandom));
    endfunction

    function automatic lfs_pkg::t_item rand_arm();
        lfs_pkg::t_item it;
        int pick;
        it = rand_item();
        it.func = lfs_pkg::FUNC_ARM;
        if ($urandom_range(0, 4) != 0) it.color = 3'($urandom_range(0, 4));
        pick = $urandom_range(0, 99);
        if (pick < 70) it.count = 8'd1;
        else if (pick < 85) it.count = 8'd2;
        else if (pick < 95) it.count = 8'($urandom);
        else it.count = 8'd0;
        it.fast = ($urandom_range(0, 99) < 85);
        return it;
    endfunction

    task automatic queue_item(lfs_pkg::t_item it);
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic queue_boot_update();
        lfs_pkg::t_item it;
        it = rand_item();
        it.func = lfs_pkg::FUNC_BOOT;
        queue_item(it);
    endtask

    // arm, then ticks to play the burst out or leave it running, with stray items mixed in
    task automatic queue_burst_session();
        lfs_pkg::t_item arm_it;
        lfs_pkg::t_item it;
        int span;
        int on_ms;
        int off_ms;
        if ($urandom_range(0, 3) == 0) queue_boot_update();
        arm_it = rand_arm();
        queue_item(arm_it);
        if ($urandom_range(0, 2) == 0) queue_boot_update();
        on_ms = arm_it.fast ? int'(lfs_pkg::FAST_ON_MS) : int'(lfs_pkg::SLOW_ON_MS);
        off_ms = arm_it.fast ? int'(lfs_pkg::FAST_OFF_MS) : int'(lfs_pkg::SLOW_OFF_MS);
        if (arm_it.count == 8'd0) span = 3;
        else if (arm_it.count <= 8'd2) span = 1 + on_ms + (arm_it.count - 1) * (on_ms + off_ms);
        else span = $urandom_range(40, SPAN_CAP);
        if (span > SPAN_CAP) span = SPAN_CAP;
        span += $urandom_range(0, 4);
        while (span > 0) begin
            if ($urandom_range(0, 99) < 8) begin
                queue_item(rand_item());
            end else begin
                it = rand_item();
                it.func = lfs_pkg::FUNC_TICK;
                queue_item(it);
                span--;
            end
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [lfs_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            lfs_pkg::CFG_MODE: cfg_now.behaviour_mode = val[1:0];
            lfs_pkg::CFG_PRESENT: cfg_now.present_mask = val[3:0];
            lfs_pkg::CFG_INT_INV: cfg_now.internal_invert = val[0];
            lfs_pkg::CFG_RGB_INV: cfg_now.rgb_invert = val[0];
            lfs_pkg::CFG_METER_PIN: cfg_now.meter_pin_present = val[0];
            default: ;
        endcase
    endtask

    task automatic load_config(lfs_pkg::t_cfg c);
        write_reg(lfs_pkg::CFG_MODE, lfs_pkg::CFG_DATA_W'(c.behaviour_mode));
        write_reg(lfs_pkg::CFG_PRESENT, lfs_pkg::CFG_DATA_W'(c.present_mask));
        write_reg(lfs_pkg::CFG_INT_INV, lfs_pkg::CFG_DATA_W'(c.internal_invert));
        write_reg(lfs_pkg::CFG_RGB_INV, lfs_pkg::CFG_DATA_W'(c.rgb_invert));
        write_reg(lfs_pkg::CFG_METER_PIN, lfs_pkg::CFG_DATA_W'(c.meter_pin_present));
    endtask

    // every queued item accepted and every result taken
    task automatic wait_idle();
        while (items_sent != items_queued || expected_levels.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        lfs_pkg::t_cfg phase_cfg[7];
        int tx_pct[7];
        int rx_pct[7];
        int start;
        phase_cfg[0] = '{lfs_pkg::MODE_NORMAL, 4'hF, 1'b0, 1'b0, 1'b1};
        phase_cfg[1] = '{lfs_pkg::MODE_BOOT, 4'hF, 1'b1, 1'b1, 1'b1};
        phase_cfg[2] = '{lfs_pkg::MODE_ERROR, 4'b1011, 1'b0, 1'b1, 1'b1};
        phase_cfg[3] = '{lfs_pkg::MODE_OFF, 4'hF, 1'b1, 1'b0, 1'b1};
        phase_cfg[4] = '{lfs_pkg::MODE_NORMAL, 4'b0110, 1'b1, 1'b1, 1'b0};
        phase_cfg[5] = '{lfs_pkg::MODE_BOOT, 4'b1101, 1'b0, 1'b0, 1'b1};
        phase_cfg[6] = '{2'($urandom_range(0, 2)), 4'($urandom), 1'($urandom),
                         1'($urandom), 1'($urandom)};
        tx_pct = '{30, 0, 0, 50, 20, 10, 25};
        rx_pct = '{30, 0, 20, 50, 0, 40, 25};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: nothing fitted, no meter pin
        queue_item(make_item(FUNC_NOP, 3'd7, 8'hFF, 1'b1, 1'b1, 1'b1));
        queue_item(make_item(lfs_pkg::FUNC_ARM, lfs_pkg::COL_YELLOW, 8'd1, 1'b1, 1'b0, 1'b0));
        wait_idle();

        load_config(phase_cfg[0]);
        queue_item(make_item(lfs_pkg::FUNC_TICK, lfs_pkg::COL_INTERNAL, 8'd0, 1'b0, 1'b0, 1'b0));
        queue_item(make_item(lfs_pkg::FUNC_ARM, lfs_pkg::COL_RED, 8'd0, 1'b1, 1'b0, 1'b0));
        queue_item(make_item(lfs_pkg::FUNC_ARM, 3'd7, 8'hFF, 1'b1, 1'b1, 1'b1));
        queue_item(make_item(lfs_pkg::FUNC_ARM, 3'd5, 8'd1, 1'b0, 1'b0, 1'b0));
        queue_item(make_item(lfs_pkg::FUNC_ARM, 3'd6, 8'd1, 1'b0, 1'b0, 1'b0));
        queue_item(make_item(lfs_pkg::FUNC_ARM, lfs_pkg::COL_YELLOW, 8'd1, 1'b1, 1'b1, 1'b0));
        queue_item(make_item(lfs_pkg::FUNC_ARM, lfs_pkg::COL_BLUE, 8'd3, 1'b0, 1'b0, 1'b0));
        queue_item(make_item(lfs_pkg::FUNC_BOOT, lfs_pkg::COL_INTERNAL, 8'd0, 1'b0, 1'b0, 1'b1));
        queue_item(make_item(lfs_pkg::FUNC_BOOT, lfs_pkg::COL_INTERNAL, 8'd0, 1'b0, 1'b0, 1'b1));
        queue_item(make_item(lfs_pkg::FUNC_BOOT, lfs_pkg::COL_INTERNAL, 8'd0, 1'b0, 1'b0, 1'b0));
        queue_item(make_item(lfs_pkg::FUNC_TICK, 3'd7, 8'hFF, 1'b1, 1'b1, 1'b1));
        queue_item(make_item(lfs_pkg::FUNC_ARM, lfs_pkg::COL_INTERNAL, 8'd2, 1'b0, 1'b0, 1'b0));
        queue_item(make_item(lfs_pkg::FUNC_ARM, lfs_pkg::COL_GREEN, 8'd2, 1'b1, 1'b0, 1'b0));
        queue_item(make_item(FUNC_NOP, lfs_pkg::COL_INTERNAL, 8'd0, 1'b0, 1'b0, 1'b0));
        wait_idle();

        for (int p = 0; p < 7; p++) begin
            if (p != 0) load_config(phase_cfg[p]);
            tx_idle_pct = tx_pct[p];
            rx_stall_pct = rx_pct[p];
            start = items_queued;
            while (items_queued - start < PHASE_ITEMS) queue_burst_session();
            // output side held off while items keep coming
            if (p == 2) holds_asked = holds_asked + 1;
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        $display("run covered %0d items and %0d results over 8 register settings",
                 items_sent, results_seen);
        $display("%0d bursts armed, %0d pulses lit, %0d pulses held dark by the mode",
                 bursts_armed, pulses_lit, pulses_dark);
        if (errors == 0 && expected_levels.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #3000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
